@@ hw/rtl/mvdc_pkg.sv @@
// shared types, widths and constants for the mesh vertex degree classifier
// no dependencies
package mvdc_pkg;

    localparam int IDX_W       = 10;
    localparam int CNT_W       = 8;
    localparam int CLASS_W     = 3;
    localparam int CFG_W       = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [CNT_W-1:0] DEGREE_MAX         = 8'd255;
    localparam logic [CNT_W-1:0] MIN_CLASSED_DEGREE = 8'd3;
    localparam logic [CNT_W-1:0] MAX_CLASSED_DEGREE = 8'd8;

    typedef struct packed {
        logic             is_read;
        logic             range_err;
        logic [IDX_W-1:0] index;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [CLASS_W-1:0] class_of(input logic [CNT_W-1:0] deg);
        logic [CNT_W-1:0] offs;
        offs = deg - (MIN_CLASSED_DEGREE - 8'd1);
        if (deg inside {[MIN_CLASSED_DEGREE:MAX_CLASSED_DEGREE]})
        begin
            return offs[CLASS_W-1:0];
        end
        return '0;
    endfunction

endpackage

@@ hw/rtl/mvdc_front.sv @@
// front end: point_count register, range checks and op classification
// depends on mvdc_pkg
module mvdc_front
    import mvdc_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    req_type,
    input  logic signed [CFG_W-1:0] corner_index,
    input  logic [IDX_W-1:0]        point_index,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic                    push,
    output op_t                     op
);

    localparam int LIM_W = ($clog2(MAX_POINTS + 1) > CFG_W) ? $clog2(MAX_POINTS + 1) : CFG_W;

    logic [CFG_W-1:0] point_count_reg;
    logic [CFG_W-1:0] point_count_next;
    logic [LIM_W-1:0] pc_ext;
    logic [LIM_W-1:0] lim;
    logic             is_read;
    logic             corner_ok;
    logic             read_ok;

    assign point_count_next = cfg_we ? cfg_data : point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else
        begin
            point_count_reg <= point_count_next;
        end
    end

    assign pc_ext    = LIM_W'(point_count_reg);
    assign lim       = (pc_ext > LIM_W'(MAX_POINTS)) ? LIM_W'(MAX_POINTS) : pc_ext;
    assign is_read   = (req_type == REQ_READ);
    assign corner_ok = !corner_index[CFG_W-1] && (LIM_W'(corner_index[IDX_W-1:0]) < lim);
    assign read_ok   = LIM_W'(point_index) < lim;

    // skipped corners never reach the queue
    assign push         = accept && (is_read || corner_ok);
    assign op.is_read   = is_read;
    assign op.range_err = is_read && !read_ok;
    assign op.index     = is_read ? point_index : corner_index[IDX_W-1:0];

endmodule

@@ hw/rtl/mvdc_queue.sv @@
// short op queue between front and back end
// depends on mvdc_pkg
module mvdc_queue
    import mvdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

@@ hw/rtl/mvdc_back.sv @@
// back end: counter memory, clearing pass, read-modify-write with forwarding, result register
// depends on mvdc_pkg
module mvdc_back
    import mvdc_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  queue_status_t      status,
    input  op_t                head_op,
    output logic               pop,
    output logic               clearing,
    output logic               result_valid,
    output logic [IDX_W-1:0]   point_number,
    output logic [CNT_W-1:0]   degree,
    output logic [CLASS_W-1:0] color_class,
    output logic               range_error
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    logic [CNT_W-1:0] mem [MAX_POINTS];

    logic             clr_reg;
    logic             clr_next;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    clr_addr_next;
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             fw_valid_reg;
    logic [AW-1:0]    fw_addr_reg;
    logic [CNT_W-1:0] fw_data_reg;
    logic             res_valid_reg;
    logic [IDX_W-1:0] res_point_reg;
    logic [CNT_W-1:0] res_degree_reg;
    logic [CLASS_W-1:0] res_class_reg;
    logic             res_err_reg;

    logic [XW-1:0]    head_ext;
    logic [XW-1:0]    s1_ext;
    logic [AW-1:0]    head_addr;
    logic [AW-1:0]    s1_addr;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] new_val;
    logic [CNT_W-1:0] out_degree;
    logic             mem_op;
    logic             we;
    logic [AW-1:0]    wa;
    logic [CNT_W-1:0] wd;

    assign head_ext  = XW'(head_op.index);
    assign s1_ext    = XW'(s1_op_reg.index);
    assign head_addr = head_ext[AW-1:0];
    assign s1_addr   = s1_ext[AW-1:0];

    assign pop      = !status.empty && !clr_reg;
    assign clearing = clr_reg;

    // clearing pass over the whole counter store after reset
    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            if (clr_addr_reg == AW'(MAX_POINTS - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    // write from the previous edge is not yet in the read data
    assign cur = (fw_valid_reg && (fw_addr_reg == s1_addr)) ? fw_data_reg : rd_data_reg;

    always_comb
    begin
        if (s1_op_reg.is_read)
        begin
            new_val = '0;
        end
        else if (cur == DEGREE_MAX)
        begin
            new_val = DEGREE_MAX;
        end
        else
        begin
            new_val = cur + 1'b1;
        end
    end

    assign mem_op     = s1_valid_reg && !s1_op_reg.range_err;
    assign we         = clr_reg || mem_op;
    assign wa         = clr_reg ? clr_addr_reg : s1_addr;
    assign wd         = clr_reg ? '0 : new_val;
    assign out_degree = s1_op_reg.range_err ? '0 : cur;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= pop;
            fw_valid_reg  <= mem_op;
            res_valid_reg <= s1_valid_reg && s1_op_reg.is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= head_op;
        fw_addr_reg    <= s1_addr;
        fw_data_reg    <= new_val;
        res_point_reg  <= s1_op_reg.index;
        res_degree_reg <= out_degree;
        res_class_reg  <= class_of(out_degree);
        res_err_reg    <= s1_op_reg.range_err;
    end

    assign result_valid = res_valid_reg;
    assign point_number = res_point_reg;
    assign degree       = res_degree_reg;
    assign color_class  = res_class_reg;
    assign range_error  = res_err_reg;

endmodule

@@ hw/rtl/mesh_vertex_degree_classifier_core.sv @@
// top level of the mesh vertex degree classifier
// depends on mvdc_pkg, mvdc_front, mvdc_queue, mvdc_back
//
// Takes one item per clock when start is high and busy is low. A count item bumps the
// saturating 8-bit counter of its point and gives no result; a readout item returns degree
// and colour class (or a range error) with result_valid high for one cycle once the item
// has passed the queue, the stage-1 register and the result register, and clears that
// counter. The counter store is a memory with one read and one write port: each item reads
// it one cycle and writes it the next, with forwarding between neighbouring items, so the
// sustained rate is one item per clock. After reset busy stays high while the store is
// cleared; point_count may be written during that time. The receiver cannot stall results.
module mesh_vertex_degree_classifier_core
    import mvdc_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic signed [CFG_W-1:0] corner_index,
    input  logic [IDX_W-1:0]        point_index,
    input  logic                    point_count_we,
    input  logic [CFG_W-1:0]        point_count,
    output logic                    result_valid,
    output logic [IDX_W-1:0]        point_number,
    output logic [CNT_W-1:0]        degree,
    output logic [CLASS_W-1:0]      color_class,
    output logic                    range_error
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          clearing;
    op_t           push_op;
    op_t           head_op;
    queue_status_t q_status;

    assign busy   = clearing || q_status.full;
    assign accept = start && !busy;

    mvdc_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .corner_index (corner_index),
        .point_index  (point_index),
        .cfg_we       (point_count_we),
        .cfg_data     (point_count),
        .push         (push),
        .op           (push_op)
    );

    mvdc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    mvdc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (q_status),
        .head_op      (head_op),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .point_number (point_number),
        .degree       (degree),
        .color_class  (color_class),
        .range_error  (range_error)
    );

endmodule

@@ test/mesh_vertex_degree_classifier_core_tb.sv @@
// self-checking testbench for mesh_vertex_degree_classifier_core: directed table, then random
// count and readout transfers checked against an in-bench degree tally
// depends on mvdc_pkg and the mesh_vertex_degree_classifier_core rtl
module mesh_vertex_degree_classifier_core_tb;
    import mvdc_pkg::*;

    localparam int MAX_PTS = 1024;

    typedef struct packed {
        logic [IDX_W-1:0]   pnum;
        logic [CNT_W-1:0]   deg;
        logic [CLASS_W-1:0] cls;
        logic               err;
    } readout_t;

    typedef struct packed {
        logic                    rq;
        logic signed [CFG_W-1:0] ci;
        logic [IDX_W-1:0]        pi;
        logic                    typed;
        readout_t                want;
    } dir_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    req_type = REQ_COUNT;
    logic signed [CFG_W-1:0] corner_index = '0;
    logic [IDX_W-1:0]        point_index = '0;
    logic                    point_count_we = 1'b0;
    logic [CFG_W-1:0]        point_count = '0;
    logic                    result_valid;
    logic [IDX_W-1:0]        point_number;
    logic [CNT_W-1:0]        degree;
    logic [CLASS_W-1:0]      color_class;
    logic                    range_error;

    logic [CNT_W-1:0] vertex_tally [MAX_PTS] = '{default: '0};
    int               point_cfg = 0;
    readout_t         pending_readouts [$];
    dir_row_t         dir_rows [19];
    int               idle_pct = 0;
    int               fail_count = 0;
    int               n_counts = 0;
    int               n_reads = 0;
    int               n_checked = 0;
    int               n_range_err = 0;
    int               peak_degree = 0;

    mesh_vertex_degree_classifier_core #(
        .MAX_POINTS(MAX_PTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .corner_index(corner_index),
        .point_index(point_index),
        .point_count_we(point_count_we),
        .point_count(point_count),
        .result_valid(result_valid),
        .point_number(point_number),
        .degree(degree),
        .color_class(color_class),
        .range_error(range_error)
    );

    always #5 clk = ~clk;

    // expected outcome of one transfer; updates the tally as the block should
    task automatic tally_item(input logic rq, input logic signed [CFG_W-1:0] ci,
                              input logic [IDX_W-1:0] pi, output logic has,
                              output readout_t r);
        int lim;
        lim = (point_cfg > MAX_PTS) ? MAX_PTS : point_cfg;
        has = 1'b0;
        r = '0;
        if (rq == REQ_COUNT)
        begin
            n_counts++;
            if (!ci[CFG_W-1] && int'(ci) < lim && vertex_tally[ci[IDX_W-1:0]] != DEGREE_MAX)
            begin
                vertex_tally[ci[IDX_W-1:0]] = vertex_tally[ci[IDX_W-1:0]] + 1'b1;
            end
        end
        else
        begin
            n_reads++;
            has = 1'b1;
            r.pnum = pi;
            r.err = 1'b1;
            if (int'(pi) < lim)
            begin
                r.deg = vertex_tally[pi];
                r.err = 1'b0;
                vertex_tally[pi] = '0;
            end
            if (r.deg >= MIN_CLASSED_DEGREE && r.deg <= MAX_CLASSED_DEGREE)
            begin
                r.cls = CLASS_W'(r.deg - (MIN_CLASSED_DEGREE - 8'd1));
            end
        end
    endtask

    task automatic push_item(input logic rq, input logic signed [CFG_W-1:0] ci,
                             input logic [IDX_W-1:0] pi, input logic typed,
                             input readout_t typed_want);
        logic     has;
        readout_t got;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        corner_index <= ci;
        point_index <= pi;
        do @(posedge clk); while (busy);
        tally_item(rq, ci, pi, has, got);
        if (has)
        begin
            pending_readouts.push_back(typed ? typed_want : got);
        end
    endtask

    // wait out every expected result, then the tail of the pipeline
    task automatic settle_pipeline;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_readouts.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        point_count_we <= 1'b1;
        point_count <= CFG_W'(value);
        @(posedge clk);
        point_count_we <= 1'b0;
        point_cfg = value;
        @(posedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_point(input int lim);
        int hot;
        hot = (lim < 1) ? 1 : ((lim < 8) ? lim : 8);
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom);
            1: return IDX_W'(lim);
            2: return IDX_W'(lim - 1);
            default: return IDX_W'($urandom_range(0, hot - 1));
        endcase
    endfunction

    function automatic logic signed [CFG_W-1:0] pick_corner(input int lim);
        if ($urandom_range(0, 11) == 0)
        begin
            return {1'b1, IDX_W'($urandom)};
        end
        return {1'b0, pick_point(lim)};
    endfunction

    task automatic run_phase(input int n_items, input int lim, input int idle, input int rd_pct);
        logic rq;
        idle_pct = idle;
        for (int i = 0; i < n_items; i++)
        begin
            rq = ($urandom_range(0, 99) < rd_pct) ? REQ_READ : REQ_COUNT;
            push_item(rq, pick_corner(lim), pick_point(lim), 1'b0, '0);
        end
    endtask

    function automatic dir_row_t mk_row(input logic rq, input logic signed [CFG_W-1:0] ci,
                                        input logic [IDX_W-1:0] pi, input logic typed,
                                        input readout_t want);
        dir_row_t row;
        row.rq = rq;
        row.ci = ci;
        row.pi = pi;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && result_valid)
        begin
            if (pending_readouts.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual point %0d degree %0d",
                         $time, point_number, degree);
            end
            else
            begin
                want = pending_readouts.pop_front();
                check_field("point_number", int'(want.pnum), int'(point_number));
                check_field("degree", int'(want.deg), int'(degree));
                check_field("color_class", int'(want.cls), int'(color_class));
                check_field("range_error", int'(want.err), int'(range_error));
                n_checked++;
                if (range_error)
                begin
                    n_range_err++;
                end
                if (int'(degree) > peak_degree)
                begin
                    peak_degree = int'(degree);
                end
            end
        end
    end

    initial
    begin
        // limit 0 first: everything out of range
        dir_rows[0]  = mk_row(REQ_READ, 11'sd0, 10'd0, 1'b1, '{10'd0, 8'd0, 3'd0, 1'b1});
        dir_rows[1]  = mk_row(REQ_COUNT, 11'sd5, 10'd0, 1'b0, '0);
        dir_rows[2]  = mk_row(REQ_READ, 11'sd0, 10'd1023, 1'b1, '{10'd1023, 8'd0, 3'd0, 1'b1});
        // full limit
        dir_rows[3]  = mk_row(REQ_READ, 11'sd0, 10'd0, 1'b1, '{10'd0, 8'd0, 3'd0, 1'b0});
        dir_rows[4]  = mk_row(REQ_COUNT, -11'sd1, 10'd0, 1'b0, '0);
        dir_rows[5]  = mk_row(REQ_COUNT, -11'sd1024, 10'd1023, 1'b0, '0);
        dir_rows[6]  = mk_row(REQ_COUNT, 11'sd1023, 10'd0, 1'b0, '0);
        dir_rows[7]  = mk_row(REQ_COUNT, 11'sd1023, 10'd0, 1'b0, '0);
        dir_rows[8]  = mk_row(REQ_COUNT, 11'sd1023, 10'd0, 1'b0, '0);
        dir_rows[9]  = mk_row(REQ_READ, 11'sd0, 10'd1023, 1'b0, '0);
        dir_rows[10] = mk_row(REQ_COUNT, 11'sd6, 10'd0, 1'b0, '0);
        dir_rows[11] = mk_row(REQ_COUNT, 11'sd6, 10'd0, 1'b0, '0);
        dir_rows[12] = mk_row(REQ_COUNT, 11'sd6, 10'd0, 1'b0, '0);
        dir_rows[13] = mk_row(REQ_COUNT, 11'sd6, 10'd0, 1'b0, '0);
        dir_rows[14] = mk_row(REQ_READ, 11'sd0, 10'd6, 1'b0, '0);
        dir_rows[15] = mk_row(REQ_COUNT, 11'sd0, 10'd0, 1'b0, '0);
        dir_rows[16] = mk_row(REQ_READ, 11'sd0, 10'd0, 1'b0, '0);
        dir_rows[17] = mk_row(REQ_READ, 11'sd0, 10'd0, 1'b0, '0);
        dir_rows[18] = mk_row(REQ_READ, 11'sd0, 10'd1023, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 19; i++)
        begin
            if (i == 3)
            begin
                settle_pipeline();
                write_limit(MAX_PTS);
            end
            push_item(dir_rows[i].rq, dir_rows[i].ci, dir_rows[i].pi, dir_rows[i].typed,
                      dir_rows[i].want);
        end
        settle_pipeline();

        run_phase(80, MAX_PTS, 0, 30);
        settle_pipeline();

        write_limit(8);
        run_phase(60, 8, 62, 25);
        settle_pipeline();
        run_phase(60, 8, 62, 25);
        settle_pipeline();

        // one live point, hammered until its counter saturates
        write_limit(1);
        run_phase(420, 1, 11, 0);
        push_item(REQ_READ, 11'sd0, 10'd0, 1'b0, '0);
        push_item(REQ_READ, 11'sd0, 10'd1, 1'b0, '0);
        settle_pipeline();

        write_limit(0);
        run_phase(30, 0, 62, 40);
        settle_pipeline();

        write_limit(1023);
        run_phase(80, 1023, 0, 30);
        settle_pipeline();

        if (pending_readouts.size() != 0)
        begin
            fail_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_readouts.size());
        end
        $display("covered %0d count and %0d readout transfers over limits 0, 1, 8, 1023, 1024",
                 n_counts, n_reads);
        $display("checked %0d results, %0d range errors, peak degree %0d",
                 n_checked, n_range_err, peak_degree);
        if (fail_count == 0)
        begin
            $display("mesh_vertex_degree_classifier_core_tb: PASS");
        end
        else
        begin
            $display("mesh_vertex_degree_classifier_core_tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("mesh_vertex_degree_classifier_core_tb: FAIL");
        $finish;
    end

endmodule
